>>> hw/rtl/sws_pkg.sv
// Package: shared constants, payload structs and codes for the sliding window sender.
`timescale 1ns / 1ps
package sws_pkg;
    localparam int WINDOW_MAX_DEF    = 64;
    localparam int PENDING_DEPTH_DEF = 256;
    localparam int MAX_PAYLOAD_DEF   = 1024;

    localparam logic [1:0] MODE_NEW     = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_RESEND  = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] segment_length;
        logic [31:0] ack_number;
        logic        cumulative;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_number;
        logic [10:0] payload_length;
        logic        last;
    } t_out_item;
endpackage

>>> hw/rtl/sws_pend_mem.sv
// Pending length FIFO storage: synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps
module sws_pend_mem #(
    parameter int DEPTH = sws_pkg::PENDING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [10:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [10:0]   o_rdata
);
    logic [10:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/sws_unack_mem.sv
// Unacked list storage: sequence number and length per slot, one write and one read port.
`timescale 1ns / 1ps
module sws_unack_mem #(
    parameter int DEPTH = sws_pkg::WINDOW_MAX_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [42:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [42:0]   o_rdata
);
    logic [42:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/sliding_window_sender.sv
// Top level: sequencer around the pending FIFO and the packed unacked list.
// A new segment is queued, then read (S_SREAD) and sent (S_SEND) if the window has room;
// a refused one gets its result registered at once. One item at a time; an ack walks the
// unacked list slot by slot, then sends pending while there is room; a timeout resends each slot.
// Reset (i_rst_n low, synchronous): next sequence 1, queues empty, window register 1.
// No clearing pass; memories are read only at written entries.
`timescale 1ns / 1ps
module sliding_window_sender #(
    parameter int WINDOW_MAX    = sws_pkg::WINDOW_MAX_DEF,
    parameter int PENDING_DEPTH = sws_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_PAYLOAD   = sws_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sws_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output sws_pkg::t_out_item o_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);
    localparam int PAW = $clog2(PENDING_DEPTH);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int UAW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int UCW = $clog2(WINDOW_MAX + 1);
    localparam logic [10:0] MAXP = 11'(MAX_PAYLOAD);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SREAD = 9'b000000010,
        S_SEND  = 9'b000000100,
        S_AREAD = 9'b000001000,
        S_ACHK  = 9'b000010000,
        S_CREAD = 9'b000100000,
        S_CMOVE = 9'b001000000,
        S_TREAD = 9'b010000000,
        S_TOUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0]   r_win;
    logic [31:0]  r_next, n_next;
    logic [PAW-1:0] r_head, n_head;
    logic [PCW-1:0] r_pcnt, n_pcnt;
    logic [UCW-1:0] r_infl, n_infl;
    logic [UCW-1:0] r_idx, n_idx;   // read index
    logic [UCW-1:0] r_wr, n_wr;     // compaction write index
    logic         r_rem, n_rem;
    logic         r_cum;
    logic [31:0]  r_ackn;
    logic         r_ovalid, n_ovalid;
    sws_pkg::t_out_item r_oitem, n_oitem;
    logic [1:0]   r_mode;

    // memory ports
    logic           pm_we;
    logic [PAW-1:0] pm_waddr, pm_raddr;
    logic [10:0]    pm_wdata, pm_rdata;
    logic           um_we;
    logic [UAW-1:0] um_waddr, um_raddr;
    logic [42:0]    um_wdata, um_rdata;

    sws_pend_mem #(.DEPTH(PENDING_DEPTH), .AW(PAW)) u_pend (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata));
    sws_unack_mem #(.DEPTH(WINDOW_MAX), .AW(UAW)) u_unack (
        .i_clk(i_clk), .i_we(um_we), .i_waddr(um_waddr), .i_wdata(um_wdata),
        .i_raddr(um_raddr), .o_rdata(um_rdata));

    logic [UCW-1:0] win_eff;
    logic [10:0]    clip_len;
    logic           out_free;
    logic [31:0]    mseq;
    logic           hit;
    logic [31:0]    tail_sum;
    logic [PAW-1:0] tail_addr;
    logic [PAW-1:0] head_inc;

    assign win_eff  = (32'(r_win) > 32'(WINDOW_MAX)) ? UCW'(WINDOW_MAX) : UCW'(r_win);
    assign clip_len = (i_item.segment_length > 16'(MAX_PAYLOAD)) ? MAXP
                                                                  : i_item.segment_length[10:0];
    assign out_free = !r_ovalid || !i_stall;
    assign mseq     = um_rdata[42:11];
    assign hit      = r_cum ? (mseq <= r_ackn) : (mseq == r_ackn);

    // FIFO tail and head advance, wrapping at the queue depth
    assign tail_sum  = 32'(r_head) + 32'(r_pcnt);
    assign tail_addr = (tail_sum >= 32'(PENDING_DEPTH))
                       ? PAW'(tail_sum - 32'(PENDING_DEPTH)) : PAW'(tail_sum);
    assign head_inc  = (32'(r_head) == 32'(PENDING_DEPTH - 1)) ? '0 : r_head + PAW'(1);

    assign o_stall     = (r_state != S_IDLE) || !out_free;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_item      = r_oitem;
    assign pm_raddr    = r_head;

    // sequencer
    always_comb begin
        n_state = r_state; n_next = r_next; n_head = r_head; n_pcnt = r_pcnt;
        n_infl = r_infl; n_idx = r_idx; n_wr = r_wr; n_rem = r_rem;
        n_ovalid = r_ovalid && i_stall; n_oitem = r_oitem;
        pm_we = 1'b0; pm_waddr = tail_addr; pm_wdata = clip_len;
        um_we = 1'b0; um_waddr = r_wr[UAW-1:0]; um_wdata = um_rdata;
        um_raddr = r_idx[UAW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    unique case (i_item.mode)
                        sws_pkg::MODE_NEW: begin
                            if (32'(r_pcnt) >= 32'(PENDING_DEPTH)) begin
                                n_ovalid = 1'b1;
                                n_oitem = '{sws_pkg::KIND_REFUSED, 32'd0, clip_len, 1'b1};
                            end else begin
                                pm_we = 1'b1;
                                n_pcnt = r_pcnt + PCW'(1);
                                n_next = r_next + 32'd1;
                                if (r_infl < win_eff) n_state = S_SREAD;
                            end
                        end
                        sws_pkg::MODE_ACK: begin
                            n_idx = '0; n_wr = '0; n_rem = 1'b0;
                            um_raddr = '0;
                            if (r_infl != '0)
                                n_state = i_item.cumulative ? S_CREAD : S_AREAD;
                        end
                        sws_pkg::MODE_TIMEOUT: begin
                            n_idx = '0; um_raddr = '0;
                            if (r_infl != '0) n_state = S_TREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_SREAD: n_state = S_SEND; // pending head read in flight
            S_SEND: begin
                if (out_free) begin
                    um_we = 1'b1; um_waddr = r_infl[UAW-1:0];
                    um_wdata = {r_next - 32'(r_pcnt), pm_rdata};
                    n_head = head_inc;
                    n_pcnt = r_pcnt - PCW'(1);
                    n_infl = r_infl + UCW'(1);
                    n_ovalid = 1'b1;
                    n_oitem = '{sws_pkg::KIND_FIRST, r_next - 32'(r_pcnt), pm_rdata, 1'b1};
                    n_state = S_IDLE;
                    if (r_mode == sws_pkg::MODE_ACK && (n_infl < win_eff) && (n_pcnt != '0)
                        && (32'(n_infl) < 32'(WINDOW_MAX))) begin
                        n_oitem.last = 1'b0;
                        n_state = S_SREAD;
                    end
                end
            end
            S_AREAD: n_state = S_ACHK;
            S_ACHK: begin
                // single ack: once matched, shift the rest down one slot
                if (r_rem) begin
                    um_we = 1'b1;
                end
                if (!r_rem && hit) begin
                    n_rem = 1'b1;
                end else begin
                    n_wr = r_wr + UCW'(1);
                end
                n_idx = r_idx + UCW'(1);
                um_raddr = n_idx[UAW-1:0];
                if (n_idx == r_infl) begin
                    if (n_rem) begin
                        n_infl = r_infl - UCW'(1);
                        n_state = (n_infl < win_eff && r_pcnt != '0) ? S_SREAD : S_IDLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_AREAD;
                end
            end
            S_CREAD: n_state = S_CMOVE;
            S_CMOVE: begin
                // cumulative: keep entries above the number, compacted
                if (!hit) begin
                    um_we = 1'b1;
                    n_wr = r_wr + UCW'(1);
                end else begin
                    n_rem = 1'b1;
                end
                n_idx = r_idx + UCW'(1);
                um_raddr = n_idx[UAW-1:0];
                if (n_idx == r_infl) begin
                    n_infl = n_wr;
                    n_state = (n_rem && n_wr < win_eff && r_pcnt != '0) ? S_SREAD : S_IDLE;
                end else begin
                    n_state = S_CREAD;
                end
            end
            S_TREAD: n_state = S_TOUT;
            S_TOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_idx = r_idx + UCW'(1);
                    um_raddr = n_idx[UAW-1:0];
                    n_oitem = '{sws_pkg::KIND_RESEND, mseq, um_rdata[10:0], n_idx == r_infl};
                    n_state = (n_idx == r_infl) ? S_IDLE : S_TREAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_win <= 7'd1; r_next <= 32'd1; r_head <= '0;
            r_pcnt <= '0; r_infl <= '0; r_ovalid <= 1'b0; r_idx <= '0; r_wr <= '0;
            r_rem <= 1'b0;
        end else begin
            r_state <= n_state; r_next <= n_next; r_head <= n_head; r_pcnt <= n_pcnt;
            r_infl <= n_infl; r_ovalid <= n_ovalid; r_idx <= n_idx; r_wr <= n_wr;
            r_rem <= n_rem;
            if (i_cfg_valid) r_win <= i_cfg_data;
        end
    end

    // transaction payload registers
    always_ff @(posedge i_clk) begin
        r_oitem <= n_oitem;
        if (r_state == S_IDLE && i_valid && !o_stall) begin
            r_mode <= i_item.mode;
            r_cum  <= i_item.cumulative;
            r_ackn <= i_item.ack_number;
        end
    end
endmodule
